### design/rau_pkg.sv
// Shared constants of the rational arithmetic unit.
// Kind and status codes, result field widths. No dependencies.
package rau_pkg;

  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;
  localparam int RES_W    = 33;

  localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SUB = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MUL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DIV = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RED = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ZERO_DEN = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DIV_ZERO = 2'd2;

endpackage

### design/rau_in_if.sv
// Input channel of the rational arithmetic unit: valid/ready plus one item.
// Depends on rau_pkg.
interface rau_in_if #(
  parameter int W = 16
) ();
  logic                        valid;
  logic                        ready;
  logic [rau_pkg::KIND_W-1:0]  kind;
  logic signed [W-1:0]         a_num;
  logic signed [W-1:0]         a_den;
  logic signed [W-1:0]         b_num;
  logic signed [W-1:0]         b_den;

  modport source (output valid, kind, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, kind, a_num, a_den, b_num, b_den, output ready);
endinterface

### design/rau_out_if.sv
// Output channel of the rational arithmetic unit: valid/ready plus one result item.
// Depends on rau_pkg.
interface rau_out_if ();
  logic                          valid;
  logic                          ready;
  logic signed [rau_pkg::RES_W-1:0] res_num;
  logic signed [rau_pkg::RES_W-1:0] res_den;
  logic [rau_pkg::STATUS_W-1:0]  status;

  modport source (output valid, res_num, res_den, status, input ready);
  modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

### design/rau_div.sv
// Bit-serial signed divider with truncating quotient and remainder.
// One quotient bit per cycle. Depends on rau_pkg.
module rau_div #(
  parameter int W = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [W-1:0]             dividend_i,
  input  logic signed [W-1:0]             divisor_i,
  output logic                            done_o,
  output logic signed [rau_pkg::RES_W-1:0] quo_o,
  output logic signed [W-1:0]             rem_o
);

  localparam int CW = $clog2(W);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  rem_q, quo_q, dvs_q;
  logic          qneg_q, rneg_q;
  logic [W-1:0]  dvd_mag, dvs_mag;
  logic [W:0]    shifted, diff;

  assign dvd_mag = dividend_i[W-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign dvs_mag = divisor_i[W-1]  ? (~divisor_i + 1'b1)  : divisor_i;
  assign shifted = {rem_q, quo_q[W-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quo_q  <= dvd_mag;
      dvs_q  <= dvs_mag;
      qneg_q <= dividend_i[W-1] ^ divisor_i[W-1];
      rneg_q <= dividend_i[W-1];
    end else if (busy_q) begin
      if (!diff[W]) begin
        rem_q <= diff[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = qneg_q ? -$signed(rau_pkg::RES_W'(quo_q)) : $signed(rau_pkg::RES_W'(quo_q));
  assign rem_o  = rneg_q ? $signed(~rem_q + 1'b1) : $signed(rem_q);

endmodule

### design/rational_arithmetic_unit.sv
// Rational arithmetic unit: top level with sequencer, shared multiplier and divider.
// Depends on rau_pkg, rau_in_if, rau_out_if and rau_div.
//
// Add, subtract, multiply and divide of two fractions make three passes
// through the single registered multiplier. Reduce runs the Euclidean gcd
// on the bit-serial divider, one division per remainder step, then divides
// numerator and denominator by the gcd. Errors and unused kinds go straight
// to the done state. The input is ready only while no item is in work; a
// finished result waits in the output register, so the next item can be
// taken before it is read.
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rau_in_if.sink       in_i,
  rau_out_if.source    out_o
);

  localparam int W  = OPERAND_WIDTH;
  localparam int RW = rau_pkg::RES_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_M0   = 4'd1;
  localparam logic [3:0] S_M1   = 4'd2;
  localparam logic [3:0] S_M2   = 4'd3;
  localparam logic [3:0] S_M3   = 4'd4;
  localparam logic [3:0] S_GST  = 4'd5;
  localparam logic [3:0] S_GWT  = 4'd6;
  localparam logic [3:0] S_QNST = 4'd7;
  localparam logic [3:0] S_QNWT = 4'd8;
  localparam logic [3:0] S_QDST = 4'd9;
  localparam logic [3:0] S_QDWT = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0]                   state_q, state_d;
  logic [rau_pkg::KIND_W-1:0]   kind_q;
  logic signed [W-1:0]          an_q, ad_q, bn_q, bd_q, x_q, y_q;
  logic signed [RW-1:0]         prod_q, num_q, den_q;
  logic [rau_pkg::STATUS_W-1:0] status_q;
  logic                         out_valid_q;
  logic signed [RW-1:0]         out_num_q, out_den_q;
  logic [rau_pkg::STATUS_W-1:0] out_status_q;

  logic                 accept, kind_ok, zero_den, div_zero, out_load;
  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [2*W-1:0] prod;
  logic                 div_start, div_done;
  logic signed [W-1:0]  div_dvd, div_dvs, div_rem;
  logic signed [RW-1:0] div_quo;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  assign kind_ok  = (in_i.kind <= rau_pkg::KIND_RED);
  assign zero_den = (in_i.a_den == '0) ||
                    ((in_i.kind != rau_pkg::KIND_RED) && (in_i.b_den == '0));
  assign div_zero = (in_i.kind == rau_pkg::KIND_DIV) && (in_i.b_num == '0);

  // Shared multiplier operand select
  always_comb begin
    mul_a = an_q;
    mul_b = bd_q;
    unique case (state_q)
      S_M0: begin
        mul_a = an_q;
        mul_b = (kind_q == rau_pkg::KIND_MUL) ? bn_q : bd_q;
      end
      S_M1: begin
        mul_a = bn_q;
        mul_b = ad_q;
      end
      S_M2: begin
        mul_a = ad_q;
        mul_b = (kind_q == rau_pkg::KIND_DIV) ? bn_q : bd_q;
      end
      default: begin
        mul_a = an_q;
        mul_b = bd_q;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign div_start = (state_q == S_GST) || (state_q == S_QNST) || (state_q == S_QDST);
  assign div_dvd   = (state_q == S_GST) ? x_q : (state_q == S_QNST) ? an_q : ad_q;
  assign div_dvs   = (state_q == S_GST) ? y_q : x_q;

  rau_div #(
    .W (W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!kind_ok || zero_den || div_zero) begin
            state_d = S_DONE;
          end else if (in_i.kind == rau_pkg::KIND_RED) begin
            state_d = S_GST;
          end else begin
            state_d = S_M0;
          end
        end
      end
      S_M0:   state_d = S_M1;
      S_M1:   state_d = S_M2;
      S_M2:   state_d = S_M3;
      S_M3:   state_d = S_DONE;
      S_GST:  state_d = S_GWT;
      S_GWT: begin
        if (div_done) begin
          state_d = (div_rem == '0) ? S_QNST : S_GST;
        end
      end
      S_QNST: state_d = S_QNWT;
      S_QNWT: begin
        if (div_done) begin
          state_d = S_QDST;
        end
      end
      S_QDST: state_d = S_QDWT;
      S_QDWT: begin
        if (div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= in_i.kind;
      an_q   <= in_i.a_num;
      ad_q   <= in_i.a_den;
      bn_q   <= in_i.b_num;
      bd_q   <= in_i.b_den;
      x_q    <= in_i.a_num;
      y_q    <= in_i.a_den;
      num_q  <= '0;
      den_q  <= '0;
      if (kind_ok && zero_den) begin
        status_q <= rau_pkg::STATUS_ZERO_DEN;
      end else if (kind_ok && div_zero) begin
        status_q <= rau_pkg::STATUS_DIV_ZERO;
      end else begin
        status_q <= rau_pkg::STATUS_OK;
      end
    end
    prod_q <= RW'(prod);
    unique case (state_q)
      S_M1: num_q <= prod_q;
      S_M2: begin
        if (kind_q == rau_pkg::KIND_ADD) begin
          num_q <= num_q + prod_q;
        end else if (kind_q == rau_pkg::KIND_SUB) begin
          num_q <= num_q - prod_q;
        end
      end
      S_M3: den_q <= prod_q;
      S_GWT: begin
        if (div_done) begin
          x_q <= y_q;
          y_q <= div_rem;
        end
      end
      S_QNWT: begin
        if (div_done) begin
          num_q <= div_quo;
        end
      end
      S_QDWT: begin
        if (div_done) begin
          den_q <= div_quo;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_num_q    <= num_q;
      out_den_q    <= den_q;
      out_status_q <= status_q;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.res_num = out_num_q;
  assign out_o.res_den = out_den_q;
  assign out_o.status  = out_status_q;

endmodule
